FILE: rtl/core/esc_pkg.sv
// shared constants and helpers for the epoch seconds to calendar converter
`timescale 1ns / 1ps
package esc_pkg;

  localparam int unsigned SecsW  = 32;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned DayNumW = 16;
  localparam int unsigned TodW    = 17;
  localparam int unsigned DoyW    = 9;

  localparam int unsigned Stages = 7;

  localparam logic [24:0] DayRecip   = 25'd25451658;
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [15:0] HourRecip  = 16'd37283;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [12:0] MinRecip   = 13'd4370;
  localparam logic [5:0]  SecsPerMin = 6'd60;
  localparam logic [15:0] CycleRecip = 16'd45934;
  localparam logic [10:0] DaysPerCycle = 11'd1461;

  // days from 1968-01-01 to 1970-01-01
  localparam logic [DayNumW-1:0] BaseShift = 16'd731;
  // day number of 2100-03-01 counted from 1970-01-01
  localparam logic [DayNumW-1:0] NoLeap2100 = 16'd47541;
  localparam logic [YearW-1:0]   BaseYear = 12'd1968;

  localparam logic [DoyW-1:0] MonthFirst [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  function automatic logic [DoyW-1:0] month_first(input logic [MonthW-1:0] m,
                                                  input logic leap);
    logic [DoyW-1:0] base;
    base = (m < 4'd12) ? MonthFirst[m] : 9'd0;
    if (leap && (m >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

FILE: rtl/core/esc_in_if.sv
// input channel carrying one epoch seconds word
`timescale 1ns / 1ps
interface esc_in_if
  import esc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SecsW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

FILE: rtl/core/esc_out_if.sv
// output channel carrying one calendar date and time word
`timescale 1ns / 1ps
interface esc_out_if
  import esc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [DayW-1:0]   day_of_month;
  logic [HourW-1:0]  hour;
  logic [MinW-1:0]   minute;
  logic [SecW-1:0]   second;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, output ready);
endinterface

FILE: rtl/core/esc_days_to_date.sv
// four stage pipeline from shifted day number to year, month and day
`timescale 1ns / 1ps
module esc_days_to_date
  import esc_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [DayNumW-1:0] day_num_i,
  output logic [YearW-1:0]   year_o,
  output logic [MonthW-1:0]  month_o,
  output logic [DayW-1:0]    day_o
);

  logic [31:0]        cyc_prod;
  logic [5:0]         cyc_d, cyc_q;
  logic [DayNumW-1:0] dn_q;

  logic [DayNumW-1:0] cyc_days;
  logic [DayNumW-1:0] rd_full;
  logic [10:0]        rd_d, rd_q;
  logic [5:0]         cyc5_q;

  logic [1:0]         yo;
  logic [10:0]        doy_full;
  logic [DoyW-1:0]    doy_d, doy_q;
  logic [YearW-1:0]   yr_d, yr_q;
  logic               leap_d, leap_q;

  logic [MonthW-1:0]  mi;
  logic [DoyW-1:0]    first;
  logic [DoyW-1:0]    dom;
  logic [YearW-1:0]   year_q;
  logic [MonthW-1:0]  month_d, month_q;
  logic [DayW-1:0]    day_d, day_q;

  // four year cycle index
  assign cyc_prod = day_num_i * CycleRecip;
  assign cyc_d    = cyc_prod[31:26];

  // day within the cycle
  assign cyc_days = DayNumW'(cyc_q) * DayNumW'(DaysPerCycle);
  assign rd_full  = dn_q - cyc_days;
  assign rd_d     = rd_full[10:0];

  // year within the cycle, day of year
  always_comb begin
    priority if (rd_q < 11'd366) begin
      yo       = 2'd0;
      doy_full = rd_q;
    end else if (rd_q < 11'd731) begin
      yo       = 2'd1;
      doy_full = rd_q - 11'd366;
    end else if (rd_q < 11'd1096) begin
      yo       = 2'd2;
      doy_full = rd_q - 11'd731;
    end else begin
      yo       = 2'd3;
      doy_full = rd_q - 11'd1096;
    end
  end

  assign doy_d  = doy_full[DoyW-1:0];
  assign yr_d   = BaseYear + {4'd0, cyc5_q, 2'b00} + YearW'(yo);
  assign leap_d = (yo == 2'd0);

  // month split
  always_comb begin
    mi = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy_q >= month_first(MonthW'(k), leap_q)) begin
        mi = mi + 4'd1;
      end
    end
  end

  assign first   = month_first(mi, leap_q);
  assign dom     = doy_q - first + 9'd1;
  assign month_d = mi + 4'd1;
  assign day_d   = dom[DayW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cyc_q   <= cyc_d;
      dn_q    <= day_num_i;
      rd_q    <= rd_d;
      cyc5_q  <= cyc_q;
      doy_q   <= doy_d;
      yr_q    <= yr_d;
      leap_q  <= leap_d;
      year_q  <= yr_q;
      month_q <= month_d;
      day_q   <= day_d;
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

FILE: rtl/core/epoch_seconds_to_calendar.sv
// top level: unix seconds to utc calendar date and time of day
//
// usage
//   in_i carries one 32-bit count of seconds since 1970-01-01 00:00:00 utc
//   per word, out_o one word with year, month, day_of_month, hour, minute
//   and second in utc; every input word gives exactly one output word
//   valid/ready on both channels, a word moves when both are high
// timing
//   seven register stages; a word taken from in_i is on out_o once it has
//   passed through all seven, and leaves when out_o.ready is high
//   one word per cycle unless the pipe stalls; the stage count is set by the chain of
//   constant reciprocal multiplies (day split, hour, minute, four year cycle)
// stall
//   the whole pipe holds while the output word waits and ready is low;
//   in_i.ready drops only when the last stage is full and not taken
// reset
//   rst_ni clears the stage valid bits, the pipe comes up empty
`timescale 1ns / 1ps
module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  esc_in_if.sink    in_i,
  esc_out_if.source out_o
);

  logic              en;
  logic [Stages-1:0] vld_d, vld_q;

  // stage 1: day estimate
  logic [49:0]        dq_prod;
  logic [DayNumW-1:0] dq_d, dq_q;
  logic [SecsW-1:0]   t_q;

  // stage 2: corrected day and second of day
  logic [32:0]        rm_full;
  logic [17:0]        rm_raw;
  logic [DayNumW-1:0] days_d, days_q;
  logic [TodW-1:0]    tod_d, tod_q;

  // stage 3: hour and shifted day number
  logic [32:0]        hr_prod;
  logic [HourW-1:0]   hr_d, hr3_q;
  logic [DayNumW-1:0] dn_d, dn_q;
  logic [TodW-1:0]    tod3_q;

  // stage 4: second of hour
  logic [TodW-1:0]    mr_full;
  logic [11:0]        mr_d, mr4_q;
  logic [HourW-1:0]   hr4_q;

  // stage 5: minute
  logic [24:0]        mn_prod;
  logic [MinW-1:0]    mn_d, mn5_q;
  logic [11:0]        mr5_q;
  logic [HourW-1:0]   hr5_q;

  // stage 6: second
  logic [11:0]        sc_full;
  logic [SecW-1:0]    sc_d, sc6_q;
  logic [MinW-1:0]    mn6_q;
  logic [HourW-1:0]   hr6_q;

  // stage 7: output word
  logic [SecW-1:0]    sc7_q;
  logic [MinW-1:0]    mn7_q;
  logic [HourW-1:0]   hr7_q;

  assign en         = ~vld_q[Stages-1] | out_o.ready;
  assign in_i.ready = en;
  assign vld_d      = {vld_q[Stages-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign dq_prod = in_i.epoch_seconds[SecsW-1:7] * DayRecip;
  assign dq_d    = dq_prod[49:34];

  assign rm_full = {1'b0, t_q} - (33'(dq_q) * 33'(SecsPerDay));
  assign rm_raw  = rm_full[17:0];

  always_comb begin
    if (rm_raw >= 18'(SecsPerDay)) begin
      days_d = dq_q + 16'd1;
      tod_d  = TodW'(rm_raw - 18'(SecsPerDay));
    end else begin
      days_d = dq_q;
      tod_d  = rm_raw[TodW-1:0];
    end
  end

  assign hr_prod = tod_q * HourRecip;
  assign hr_d    = hr_prod[31:27];
  // phantom feb 29 in 2100 keeps the four year cycle regular
  assign dn_d    = days_q + BaseShift + DayNumW'(days_q >= NoLeap2100);

  assign mr_full = tod3_q - (TodW'(hr3_q) * TodW'(SecsPerHour));
  assign mr_d    = mr_full[11:0];

  assign mn_prod = mr4_q * MinRecip;
  assign mn_d    = mn_prod[23:18];

  assign sc_full = mr5_q - (12'(mn5_q) * 12'(SecsPerMin));
  assign sc_d    = sc_full[SecW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q    <= in_i.epoch_seconds;
      dq_q   <= dq_d;
      days_q <= days_d;
      tod_q  <= tod_d;
      hr3_q  <= hr_d;
      dn_q   <= dn_d;
      tod3_q <= tod_q;
      mr4_q  <= mr_d;
      hr4_q  <= hr3_q;
      mn5_q  <= mn_d;
      mr5_q  <= mr4_q;
      hr5_q  <= hr4_q;
      sc6_q  <= sc_d;
      mn6_q  <= mn5_q;
      hr6_q  <= hr5_q;
      sc7_q  <= sc6_q;
      mn7_q  <= mn6_q;
      hr7_q  <= hr6_q;
    end
  end

  esc_days_to_date u_date (
    .clk_i     (clk_i),
    .en_i      (en),
    .day_num_i (dn_q),
    .year_o    (out_o.year),
    .month_o   (out_o.month),
    .day_o     (out_o.day_of_month)
  );

  assign out_o.valid  = vld_q[Stages-1];
  assign out_o.hour   = hr7_q;
  assign out_o.minute = mn7_q;
  assign out_o.second = sc7_q;

endmodule
